// ===== rtl/matrix_saddle_point_finder_assert.svh =====
// Assertion macros for the matrix saddle point finder.
`ifndef MATRIX_SADDLE_POINT_FINDER_ASSERT_SVH
`define MATRIX_SADDLE_POINT_FINDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MSPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("saddle point finder: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define MSPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("saddle point finder: next-cycle check failed");

`endif

// ===== rtl/mspf_pkg.sv =====
// Shared types and constants of the matrix saddle point finder.
`default_nettype none

package mspf_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 3;
    localparam int COUNT_W   = 4;
    localparam int ORDER_W   = 4;
    localparam int PADDR_W   = 2;
    localparam int PDATA_W   = 32;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;
    localparam logic [PADDR_W-1:0] ADDR_ORDER  = 2'd0;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_elem;
        logic scan_init;
        logic row_issue;
        logic col_begin;
        logic col_issue;
        logic next_row;
        logic emit_point;
        logic emit_done;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic load_last;
        logic idx_last;
        logic row_last;
        logic is_saddle;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/mspf_ctrl.sv =====
// Controller state machine of the matrix saddle point finder.
`default_nettype none

module mspf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_elem_valid,
    input  wire mspf_pkg::t_status i_status,
    output logic                  o_elem_ready,
    output mspf_pkg::t_cmd        o_cmd
);

    typedef enum logic [6:0] {
        S_LOAD    = 7'b0000001,
        S_ROW     = 7'b0000010,
        S_ROW_END = 7'b0000100,
        S_COL     = 7'b0001000,
        S_COL_END = 7'b0010000,
        S_CHECK   = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   elem_acc;

    assign o_elem_ready = (r_state == S_LOAD);
    assign elem_acc     = i_elem_valid && o_elem_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (elem_acc) begin
                    o_cmd.wr_elem = 1'b1;
                    if (i_status.load_last) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_ROW;
                    end
                end
            end
            S_ROW: begin
                o_cmd.row_issue = 1'b1;
                if (i_status.idx_last) begin
                    n_state = S_ROW_END;
                end
            end
            S_ROW_END: begin
                // last row compare lands now; point the reads at the min column
                o_cmd.col_begin = 1'b1;
                n_state         = S_COL;
            end
            S_COL: begin
                o_cmd.col_issue = 1'b1;
                if (i_status.idx_last) begin
                    n_state = S_COL_END;
                end
            end
            S_COL_END: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_status.is_saddle || i_status.out_free) begin
                    o_cmd.emit_point = i_status.is_saddle;
                    if (i_status.row_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.next_row = 1'b1;
                        n_state        = S_ROW;
                    end
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mspf_datapath.sv =====
// Datapath of the matrix saddle point finder: element store, scan compares, result register.
`default_nettype none

module mspf_datapath #(
    parameter int MAX_ORDER = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire mspf_pkg::t_cmd                        i_cmd,
    input  wire logic [$clog2(MAX_ORDER+1)-1:0]        i_n,
    input  wire logic                                  i_load_clr,
    input  wire logic signed [mspf_pkg::DATA_W-1:0]    i_element_value,
    input  wire logic                                  i_res_ready,
    output mspf_pkg::t_status                          o_status,
    output logic                                       o_res_valid,
    output logic                                       o_item_kind,
    output logic [mspf_pkg::POS_W-1:0]                 o_point_row,
    output logic [mspf_pkg::POS_W-1:0]                 o_point_column,
    output logic signed [mspf_pkg::DATA_W-1:0]         o_point_value,
    output logic [mspf_pkg::COUNT_W-1:0]               o_points_found,
    output logic                                       o_last_result
);

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int NW    = $clog2(MAX_ORDER + 1);

    logic signed [mspf_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [mspf_pkg::DATA_W-1:0] r_rd_data;

    // load side
    logic [AW-1:0] r_load_addr;
    logic [RW-1:0] r_load_row;
    logic [RW-1:0] r_load_col;

    // scan side
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_base;
    logic [RW-1:0] r_idx;
    logic [RW-1:0] r_row;
    logic          r_cmp_row;
    logic          r_cmp_col;
    logic [RW-1:0] r_cmp_idx;
    logic signed [mspf_pkg::DATA_W-1:0] r_min;
    logic signed [mspf_pkg::DATA_W-1:0] n_min;
    logic [RW-1:0] r_min_col;
    logic [RW-1:0] n_min_col;
    logic signed [mspf_pkg::DATA_W-1:0] r_max;
    logic [RW-1:0] r_max_row;
    logic [mspf_pkg::COUNT_W-1:0] r_found;

    logic [NW-1:0] n_last;
    logic [AW-1:0] n_step;
    logic          cmp_first;
    logic          out_free;

    assign n_last    = i_n - NW'(1);
    assign n_step    = AW'(i_n);
    assign cmp_first = (r_cmp_idx == '0);
    assign out_free  = !o_res_valid || i_res_ready;

    assign o_status.load_last = (NW'(r_load_row) == n_last) && (NW'(r_load_col) == n_last);
    assign o_status.idx_last  = (NW'(r_idx) == n_last);
    assign o_status.row_last  = (NW'(r_row) == n_last);
    assign o_status.is_saddle = (r_max_row == r_row);
    assign o_status.out_free  = out_free;

    // Row minimum: a tie moves to the later column.
    always_comb begin
        n_min     = r_min;
        n_min_col = r_min_col;
        if (r_cmp_row && (cmp_first || (r_min >= r_rd_data))) begin
            n_min     = r_rd_data;
            n_min_col = r_cmp_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_elem) begin
            mem[r_load_addr] <= i_element_value;
        end
        r_rd_data <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_addr <= '0;
            r_load_row  <= '0;
            r_load_col  <= '0;
        end else if (i_load_clr || (i_cmd.wr_elem && o_status.load_last)) begin
            r_load_addr <= '0;
            r_load_row  <= '0;
            r_load_col  <= '0;
        end else if (i_cmd.wr_elem) begin
            r_load_addr <= r_load_addr + AW'(1);
            if (NW'(r_load_col) == n_last) begin
                r_load_col <= '0;
                r_load_row <= r_load_row + RW'(1);
            end else begin
                r_load_col <= r_load_col + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_row <= 1'b0;
            r_cmp_col <= 1'b0;
            r_addr    <= '0;
            r_base    <= '0;
            r_idx     <= '0;
            r_row     <= '0;
            r_found   <= '0;
        end else begin
            r_cmp_row <= i_cmd.row_issue;
            r_cmp_col <= i_cmd.col_issue;
            if (i_cmd.scan_init) begin
                r_addr  <= '0;
                r_base  <= '0;
                r_idx   <= '0;
                r_row   <= '0;
                r_found <= '0;
            end else if (i_cmd.row_issue) begin
                r_addr <= r_addr + AW'(1);
                r_idx  <= r_idx + RW'(1);
            end else if (i_cmd.col_begin) begin
                r_addr <= AW'(n_min_col);
                r_idx  <= '0;
            end else if (i_cmd.col_issue) begin
                r_addr <= r_addr + n_step;
                r_idx  <= r_idx + RW'(1);
            end
            if (i_cmd.next_row) begin
                r_addr <= r_base + n_step;
                r_base <= r_base + n_step;
                r_idx  <= '0;
                r_row  <= r_row + RW'(1);
            end
            if (i_cmd.emit_point && (r_found != '1)) begin
                r_found <= r_found + mspf_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        r_min     <= n_min;
        r_min_col <= n_min_col;
        // Column maximum: a tie moves to the later row.
        if (r_cmp_col && (cmp_first || (r_max <= r_rd_data))) begin
            r_max     <= r_rd_data;
            r_max_row <= r_cmp_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else if (i_cmd.emit_point || i_cmd.emit_done) begin
            o_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            o_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_point) begin
            o_item_kind    <= mspf_pkg::KIND_POINT;
            o_point_row    <= mspf_pkg::POS_W'(r_row);
            o_point_column <= mspf_pkg::POS_W'(r_min_col);
            o_point_value  <= r_min;
            o_points_found <= '0;
            o_last_result  <= 1'b0;
        end else if (i_cmd.emit_done) begin
            o_item_kind    <= mspf_pkg::KIND_DONE;
            o_point_row    <= '0;
            o_point_column <= '0;
            o_point_value  <= '0;
            o_points_found <= r_found;
            o_last_result  <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/matrix_saddle_point_finder.sv =====
// Timing: elements load at one per cycle; then each row is scanned for its minimum, the column
// of that minimum for its maximum, and the done item is registered once the last row is checked.
// No element of the next matrix is taken until the done item is issued; scan speed is set by the
// single read port of the element store that both scans share.
// Reset: synchronous, active low; order returns to 8, loading restarts at row 0, column 0,
// and the element store keeps its contents.
`default_nettype none

`include "matrix_saddle_point_finder_assert.svh"

module matrix_saddle_point_finder #(
    parameter int MAX_ORDER = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mspf_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [mspf_pkg::PDATA_W-1:0]         pwdata,
    output logic [mspf_pkg::PDATA_W-1:0]              prdata,
    output logic                                      pready,
    input  wire logic                                 i_elem_valid,
    output logic                                      o_elem_ready,
    input  wire logic signed [mspf_pkg::DATA_W-1:0]   i_element_value,
    output logic                                      o_res_valid,
    input  wire logic                                 i_res_ready,
    output logic                                      o_item_kind,
    output logic [mspf_pkg::POS_W-1:0]                o_point_row,
    output logic [mspf_pkg::POS_W-1:0]                o_point_column,
    output logic signed [mspf_pkg::DATA_W-1:0]        o_point_value,
    output logic [mspf_pkg::COUNT_W-1:0]              o_points_found,
    output logic                                      o_last_result
);

    localparam int NW = $clog2(MAX_ORDER + 1);

    logic [mspf_pkg::ORDER_W-1:0] r_order;
    logic [NW-1:0]                eff_n;
    logic                         cfg_wr;
    mspf_pkg::t_cmd               s_cmd;
    mspf_pkg::t_status            s_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == mspf_pkg::ADDR_ORDER);
    assign prdata = (paddr == mspf_pkg::ADDR_ORDER) ?
                    mspf_pkg::PDATA_W'(r_order) : '0;

    // Clamp order to the range the store holds.
    always_comb begin
        if (r_order == '0) begin
            eff_n = NW'(1);
        end else if (r_order > MAX_ORDER) begin
            eff_n = NW'(MAX_ORDER);
        end else begin
            eff_n = NW'(r_order);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= mspf_pkg::ORDER_RESET;
        end else if (cfg_wr) begin
            r_order <= pwdata[mspf_pkg::ORDER_W-1:0];
        end
    end

    mspf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem_valid (i_elem_valid),
        .i_status     (s_status),
        .o_elem_ready (o_elem_ready),
        .o_cmd        (s_cmd)
    );

    mspf_datapath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .i_n             (eff_n),
        .i_load_clr      (cfg_wr),
        .i_element_value (i_element_value),
        .i_res_ready     (i_res_ready),
        .o_status        (s_status),
        .o_res_valid     (o_res_valid),
        .o_item_kind     (o_item_kind),
        .o_point_row     (o_point_row),
        .o_point_column  (o_point_column),
        .o_point_value   (o_point_value),
        .o_points_found  (o_points_found),
        .o_last_result   (o_last_result)
    );

    // Only a done transaction may wait at the output while elements are taken.
    `MSPF_ASSERT_IMP(a_wait_is_done, i_clk, i_rst_n, o_res_valid && o_elem_ready, o_last_result)
    // A point is issued only for a saddle row and only into a free output register.
    `MSPF_ASSERT_IMP(a_emit_ok, i_clk, i_rst_n, s_cmd.emit_point,
                     s_status.is_saddle && s_status.out_free)
    // The done item shows up right after it is issued, with a count no larger than MAX_ORDER.
    `MSPF_ASSERT_NXT(a_done_out, i_clk, i_rst_n, s_cmd.emit_done,
                     o_res_valid && o_last_result && (o_points_found <= MAX_ORDER))

endmodule

`default_nettype wire

// ===== tb/matrix_saddle_point_finder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the matrix saddle point finder: directed rows, then random matrices.
module matrix_saddle_point_finder_tb;

    localparam int MAX_ORDER    = 8;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 195;
    localparam int SCAN_WAIT    = MAX_ORDER * (2 * MAX_ORDER + 3) + 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_DIRECTED = 25;
    localparam int NUM_ORDERS   = 11;

    typedef struct packed {
        logic                         kind;
        logic [mspf_pkg::POS_W-1:0]   row;
        logic [mspf_pkg::POS_W-1:0]   col;
        logic [mspf_pkg::DATA_W-1:0]  value;
        logic [mspf_pkg::COUNT_W-1:0] found;
        logic                         last;
    } t_saddle_item;

    typedef struct packed {
        bit                           wr;
        logic [mspf_pkg::ORDER_W-1:0] ord;
        logic [mspf_pkg::DATA_W-1:0]  value;
        bit                           typed;
        bit                           has_point;
        logic [mspf_pkg::POS_W-1:0]   row;
        logic [mspf_pkg::POS_W-1:0]   col;
        logic [mspf_pkg::COUNT_W-1:0] found;
    } t_directed_row;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          psel       = 1'b0;
    logic                          penable    = 1'b0;
    logic                          pwrite     = 1'b0;
    logic [mspf_pkg::PADDR_W-1:0]  paddr      = '0;
    logic [mspf_pkg::PDATA_W-1:0]  pwdata     = '0;
    logic [mspf_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          elem_valid = 1'b0;
    logic                          o_elem_ready;
    logic [mspf_pkg::DATA_W-1:0]   elem_value = '0;
    logic                          o_res_valid;
    logic                          res_ready  = 1'b0;
    logic                          o_item_kind;
    logic [mspf_pkg::POS_W-1:0]    o_point_row;
    logic [mspf_pkg::POS_W-1:0]    o_point_column;
    logic [mspf_pkg::DATA_W-1:0]   o_point_value;
    logic [mspf_pkg::COUNT_W-1:0]  o_points_found;
    logic                          o_last_result;

    // Shadow state of the block
    logic signed [mspf_pkg::DATA_W-1:0] shadow_matrix [MAX_ORDER*MAX_ORDER];
    logic [mspf_pkg::ORDER_W-1:0]       shadow_order      = mspf_pkg::ORDER_RESET;
    int                                 shadow_load_count = 0;

    t_saddle_item  pending_saddle_items [$];
    t_saddle_item  typed_items [$];
    t_saddle_item  oldest_item;
    t_directed_row directed_rows [NUM_DIRECTED];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int cycle_count    = 0;

    matrix_saddle_point_finder #(
        .MAX_ORDER(MAX_ORDER)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_elem_valid   (elem_valid),
        .o_elem_ready   (o_elem_ready),
        .i_element_value(elem_value),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (res_ready),
        .o_item_kind    (o_item_kind),
        .o_point_row    (o_point_row),
        .o_point_column (o_point_column),
        .o_point_value  (o_point_value),
        .o_points_found (o_points_found),
        .o_last_result  (o_last_result)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic int effective_order(input logic [mspf_pkg::ORDER_W-1:0] ord);
        if (ord == 0)
            return 1;
        if (ord > MAX_ORDER)
            return MAX_ORDER;
        return int'(ord);
    endfunction

    function automatic t_saddle_item make_item(input logic kind, input int row, input int col,
                                               input logic [mspf_pkg::DATA_W-1:0] value,
                                               input int found, input logic last);
        t_saddle_item item;
        item.kind  = kind;
        item.row   = mspf_pkg::POS_W'(row);
        item.col   = mspf_pkg::POS_W'(col);
        item.value = value;
        item.found = mspf_pkg::COUNT_W'(found);
        item.last  = last;
        return item;
    endfunction

    // Store one element; on the last element of the matrix, search it for saddle points.
    function automatic void accept_element(input logic [mspf_pkg::DATA_W-1:0] value);
        t_saddle_item                       found_items [$];
        logic signed [mspf_pkg::DATA_W-1:0] min_val;
        logic signed [mspf_pkg::DATA_W-1:0] max_val;
        int                                 n;
        int                                 min_col;
        int                                 max_row;
        int                                 found;
        n = effective_order(shadow_order);
        if (shadow_load_count >= n * n)
            shadow_load_count = 0;
        shadow_matrix[shadow_load_count] = value;
        shadow_load_count++;
        if (shadow_load_count == n * n) begin
            shadow_load_count = 0;
            found = 0;
            for (int r = 0; r < n; r++) begin
                min_val = shadow_matrix[r * n];
                min_col = 0;
                for (int c = 0; c < n; c++) begin
                    if (shadow_matrix[r * n + c] <= min_val) begin
                        min_val = shadow_matrix[r * n + c];
                        min_col = c;
                    end
                end
                max_val = shadow_matrix[min_col];
                max_row = 0;
                for (int k = 0; k < n; k++) begin
                    if (shadow_matrix[k * n + min_col] >= max_val) begin
                        max_val = shadow_matrix[k * n + min_col];
                        max_row = k;
                    end
                end
                if (max_row == r) begin
                    found_items.push_back(make_item(mspf_pkg::KIND_POINT, r, min_col, min_val,
                                                    0, 1'b0));
                    if (found < 15)
                        found++;
                end
            end
            found_items.push_back(make_item(mspf_pkg::KIND_DONE, 0, 0, '0, found, 1'b1));
        end
        // Typed-in rows replace what the search computed
        if (typed_items.size() > 0) begin
            found_items = typed_items;
            typed_items.delete();
        end
        foreach (found_items[i])
            pending_saddle_items.push_back(found_items[i]);
    endfunction

    // Offer one element and hold it until the transaction completes; enter and leave at negedge.
    task automatic send_element(input logic [mspf_pkg::DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            elem_valid <= 1'b0;
            @(negedge i_clk);
        end
        elem_valid <= 1'b1;
        elem_value <= value;
        do @(posedge i_clk); while (!o_elem_ready);
        accept_element(value);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected result has arrived.
    task automatic drain_results();
        elem_valid <= 1'b0;
        while (pending_saddle_items.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic read_order(input logic [mspf_pkg::ORDER_W-1:0] want);
        logic [mspf_pkg::PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= mspf_pkg::ADDR_ORDER;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== mspf_pkg::PDATA_W'(want))
            flag_mismatch($sformatf("order readback: expected %0d, got %0h", want, got));
    endtask

    task automatic configure_order(input logic [mspf_pkg::ORDER_W-1:0] value);
        drain_results();
        // A partial load may still be settling inside the block
        repeat (shadow_load_count != 0 ? SCAN_WAIT : 4) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mspf_pkg::ADDR_ORDER;
        pwdata  <= mspf_pkg::PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_order      = value;
        shadow_load_count = 0;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        read_order(value);
    endtask

    // Result side: random stalls, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_requests != hold_served) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else begin
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && res_ready) begin
            results_seen++;
            if (pending_saddle_items.size() == 0) begin
                flag_mismatch($sformatf("unexpected result: kind %0d row %0d col %0d value %0d",
                                        o_item_kind, o_point_row, o_point_column,
                                        $signed(o_point_value)));
            end else begin
                oldest_item = pending_saddle_items.pop_front();
                if (o_item_kind !== oldest_item.kind || o_point_row !== oldest_item.row ||
                    o_point_column !== oldest_item.col || o_point_value !== oldest_item.value ||
                    o_points_found !== oldest_item.found || o_last_result !== oldest_item.last)
                    flag_mismatch({
                        $sformatf("result %0d: expected kind %0d row %0d col %0d value %0d",
                                  results_seen, oldest_item.kind, oldest_item.row,
                                  oldest_item.col, $signed(oldest_item.value)),
                        $sformatf(" found %0d last %0d,", oldest_item.found, oldest_item.last),
                        $sformatf(" got kind %0d row %0d col %0d value %0d found %0d last %0d",
                                  o_item_kind, o_point_row, o_point_column,
                                  $signed(o_point_value), o_points_found, o_last_result)});
            end
        end
    end

    initial begin
        logic [mspf_pkg::ORDER_W-1:0]       orders [NUM_ORDERS];
        logic signed [mspf_pkg::DATA_W-1:0] cells [MAX_ORDER*MAX_ORDER];
        logic [mspf_pkg::ORDER_W-1:0]       ord;
        t_directed_row                      drow;
        int                                 random_items;
        int                                 phase;
        int                                 n;
        int                                 partial;
        int                                 mats;
        int                                 style;
        int                                 r0;
        int                                 c0;
        int                                 base;

        orders = '{4'd15, 4'd1, 4'd9, 4'd2, 4'd3, 4'd0, 4'd4, 4'd5, 4'd8, 4'd6, 4'd7};
        directed_rows = '{
            // order 1: each element is a one-by-one matrix and its own saddle point
            '{1'b1, 4'd1, 32'h7FFF_FFFF, 1'b1, 1'b1, 3'd0, 3'd0, 4'd1},
            '{1'b0, 4'd0, 32'h8000_0000, 1'b1, 1'b1, 3'd0, 3'd0, 4'd1},
            '{1'b0, 4'd0, 32'h0000_0000, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            // order 0 acts as order 1
            '{1'b1, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd0, 3'd0, 4'd1},
            // all-equal matrix: ties go to the last column and the last row
            '{1'b1, 4'd2, 32'd5, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd5, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd5, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd5, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            // partial order-3 load, then an order write discards it
            '{1'b1, 4'd3, 32'd1, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd2, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd3, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd4, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b1, 4'd2, 32'h8000_0000, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'h8000_0000, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b1, 4'd3, 32'd3, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd1, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd4, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd3, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd1, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd4, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd2, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd0, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0},
            '{1'b0, 4'd0, 32'd2, 1'b0, 1'b0, 3'd0, 3'd0, 4'd0}
        };

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        read_order(mspf_pkg::ORDER_RESET);

        send_idle_pct = 36;
        recv_idle_pct = 65;
        foreach (directed_rows[i]) begin
            drow = directed_rows[i];
            if (drow.wr)
                configure_order(drow.ord);
            if (drow.typed) begin
                if (drow.has_point)
                    typed_items.push_back(make_item(mspf_pkg::KIND_POINT, int'(drow.row),
                                                    int'(drow.col), drow.value, 0, 1'b0));
                typed_items.push_back(make_item(mspf_pkg::KIND_DONE, 0, 0, '0,
                                                int'(drow.found), 1'b1));
            end
            send_element(drow.value);
        end

        // Long result stall while order-1 elements keep coming: the block must back up
        random_items = 0;
        configure_order(4'd1);
        hold_requests++;
        repeat (16) send_element($urandom);
        random_items += 16;

        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            ord = orders[phase % NUM_ORDERS];
            phase++;
            n = effective_order(ord);
            configure_order(ord);
            if ($urandom_range(3) == 0 && n > 1) begin
                partial = $urandom_range(1, n * n - 1);
                repeat (partial) send_element($urandom);
                random_items += partial;
                configure_order(ord);
            end
            mats = (n >= 6) ? 1 : $urandom_range(1, 3);
            repeat (mats) begin
                if (random_items < 50) begin
                    send_idle_pct = 36;
                    recv_idle_pct = 65;
                end else if (random_items < 120) begin
                    send_idle_pct = 65;
                    recv_idle_pct = 36;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                for (int i = 0; i < n * n; i++)
                    cells[i] = $urandom;
                style = $urandom_range(99);
                if (style < 40) begin
                    // plant a saddle point: row above it, column below it
                    r0   = $urandom_range(n - 1);
                    c0   = $urandom_range(n - 1);
                    base = int'($urandom_range(2000000)) - 1000000;
                    for (int j = 0; j < n; j++)
                        cells[r0 * n + j] = base + int'($urandom_range(1, 1000));
                    for (int k = 0; k < n; k++)
                        cells[k * n + c0] = base - int'($urandom_range(1, 1000));
                    cells[r0 * n + c0] = base;
                end else if (style < 65) begin
                    for (int i = 0; i < n * n; i++)
                        cells[i] = int'($urandom_range(6)) - 3;
                end else if (style < 80) begin
                    for (int i = 0; i < n * n; i++) begin
                        case ($urandom_range(3))
                            0: cells[i] = 32'h8000_0000;
                            1: cells[i] = 32'h7FFF_FFFF;
                            2: cells[i] = 32'h0000_0000;
                            default: cells[i] = 32'hFFFF_FFFF;
                        endcase
                    end
                end
                for (int i = 0; i < n * n; i++)
                    send_element(cells[i]);
                random_items += n * n;
            end
        end

        drain_results();
        repeat (SCAN_WAIT) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== matrix_saddle_point_finder.f =====
+incdir+rtl
rtl/mspf_pkg.sv
rtl/mspf_ctrl.sv
rtl/mspf_datapath.sv
rtl/matrix_saddle_point_finder.sv
tb/matrix_saddle_point_finder_tb.sv
